### rtl/keypad_display_eprom_port_logic_assert.svh
// Assertion macros for the checker file of this block.
`ifndef KEYPAD_DISPLAY_EPROM_PORT_LOGIC_ASSERT_SVH
`define KEYPAD_DISPLAY_EPROM_PORT_LOGIC_ASSERT_SVH

// Checked on every rising edge of clk, switched off while rst is high.
`define KDEP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, reset cycles included.
`define KDEP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/kdep_pkg.sv
package kdep_pkg;

  // Store depth must be a power of two.
  localparam int STORE_DEPTH = 2048;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int ADDR_W      = 11;
  localparam int SEL_W       = 4;

  localparam logic [SEL_W-1:0] DIGIT_COUNT   = 4'd6;
  localparam logic [SEL_W-1:0] KEY_SEL_FIRST = 4'd6;
  localparam logic [SEL_W-1:0] KEY_SEL_LAST  = 4'd9;

  localparam logic [7:0] ERASED_BYTE = 8'hff;
  localparam logic [2:0] KEY_PAD_BITS = 3'b111;

  typedef enum logic [1:0] {
    CMD_WR_A = 2'd0,
    CMD_WR_B = 2'd1,
    CMD_RD_A = 2'd2,
    CMD_RD_B = 2'd3
  } cmd_e_t;

  typedef struct packed {
    logic capture;
    logic clear_en;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_status_t;

  // Address register modulo the store depth.
  function automatic logic [IDX_W-1:0] store_index(input logic [ADDR_W-1:0] a);
    logic [IDX_W+ADDR_W-1:0] wide;
    wide = {{IDX_W{1'b0}}, a};
    return wide[IDX_W-1:0];
  endfunction

  // Reorders a port A byte into the segment pattern, bit 0 is segment a.
  function automatic logic [6:0] segment_pattern(input logic [7:0] v);
    return {v[3], v[4], v[1], v[0], v[2], v[5], v[6]};
  endfunction

endpackage

### rtl/keypad_display_eprom_port_logic.sv
// Port logic of a small trainer board: keypad rows, six-digit display,
// serial EPROM address register and a 2K EPROM store.
// Input channel: a command word (command, port_value, key_row_0..3) is
// taken at a rising clock edge where start is high and busy is low.
// Output channel: the result word is on read_data, digit_valid,
// digit_index, segments, speaker_level, address_led, data_led and
// eprom_address for exactly one cycle, marked by done. The receiver cannot
// stall, so done never waits.
// Sequence: after the accepting edge the controller passes S_READ, then
// S_DONE with done high; busy stays high until S_DONE ends, so no new word
// is taken before the last is through. The order is set by the single store
// port: every word goes through one registered read, and a port B write
// that programs a byte writes the ANDed value back in the result cycle.
// Reset: rst is synchronous. After it the block sweeps the store, writing
// the erased value 0xFF into one entry per cycle, all 2048 entries, with
// busy high. The address register, the data latch and the last port B byte
// clear to zero, so speaker and data LED read 1 and the address LED 0.
module keypad_display_eprom_port_logic
  import kdep_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        command,
  input  logic [7:0]        port_value,
  input  logic [4:0]        key_row_0,
  input  logic [4:0]        key_row_1,
  input  logic [4:0]        key_row_2,
  input  logic [4:0]        key_row_3,
  output logic              done,
  output logic [7:0]        read_data,
  output logic              digit_valid,
  output logic [2:0]        digit_index,
  output logic [6:0]        segments,
  output logic              speaker_level,
  output logic              address_led,
  output logic              data_led,
  output logic [ADDR_W-1:0] eprom_address
);

  // Command and status groups between controller and datapath.
  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  // The controller owns the sweep, the read cycle and the result cycle.
  kdep_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .status(dp_status),
    .cmd   (ctrl_cmd),
    .busy  (busy),
    .done  (done)
  );

  // The datapath holds the port registers, the store and the result logic.
  kdep_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (ctrl_cmd),
    .status       (dp_status),
    .command      (command),
    .port_value   (port_value),
    .key_row_0    (key_row_0),
    .key_row_1    (key_row_1),
    .key_row_2    (key_row_2),
    .key_row_3    (key_row_3),
    .read_data    (read_data),
    .digit_valid  (digit_valid),
    .digit_index  (digit_index),
    .segments     (segments),
    .speaker_level(speaker_level),
    .address_led  (address_led),
    .data_led     (data_led),
    .eprom_address(eprom_address)
  );

endmodule

### rtl/kdep_ram.sv
module kdep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/kdep_ctrl.sv
module kdep_ctrl
  import kdep_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd,
  output logic       busy,
  output logic       done
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (status.clear_last) state_next = S_IDLE;
      S_IDLE:  if (start) state_next = S_READ;
      S_READ:  state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  assign cmd.capture  = (state == S_IDLE) && start;
  assign cmd.clear_en = (state == S_CLEAR);
  assign cmd.finish   = (state == S_DONE);
  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

### rtl/kdep_dpath.sv
module kdep_dpath
  import kdep_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  ctrl_cmd_t         cmd,
  output dp_status_t        status,
  input  logic [1:0]        command,
  input  logic [7:0]        port_value,
  input  logic [4:0]        key_row_0,
  input  logic [4:0]        key_row_1,
  input  logic [4:0]        key_row_2,
  input  logic [4:0]        key_row_3,
  output logic [7:0]        read_data,
  output logic              digit_valid,
  output logic [2:0]        digit_index,
  output logic [6:0]        segments,
  output logic              speaker_level,
  output logic              address_led,
  output logic              data_led,
  output logic [ADDR_W-1:0] eprom_address
);

  cmd_e_t            cmd_q;
  logic [7:0]        value_q;
  logic [4:0]        rows_q [4];
  logic [ADDR_W-1:0] address_shift;
  logic [7:0]        data_latch;
  logic [7:0]        last_port_b;
  logic              rmw_q;
  logic [IDX_W-1:0]  clr_cnt;

  logic [IDX_W-1:0]  ram_addr;
  logic              ram_we;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;
  logic [SEL_W-1:0]  sel;
  logic [1:0]        key_idx;
  logic              key_sel;
  cmd_e_t            cmd_in;

  assign cmd_in = cmd_e_t'(command);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q     <= cmd_in;
      value_q   <= port_value;
      rows_q[0] <= key_row_0;
      rows_q[1] <= key_row_1;
      rows_q[2] <= key_row_2;
      rows_q[3] <= key_row_3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      address_shift <= '0;
      data_latch    <= '0;
      last_port_b   <= '0;
      rmw_q         <= 1'b0;
    end else if (cmd.capture) begin
      rmw_q <= (cmd_in == CMD_WR_B) && port_value[6] && !last_port_b[7] && port_value[7];
      case (cmd_in)
        CMD_WR_A: data_latch <= port_value;
        CMD_WR_B: begin
          if (!last_port_b[5] && port_value[5]) begin
            address_shift <= {address_shift[ADDR_W-2:0], last_port_b[3]};
          end
          last_port_b <= port_value;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_en) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign status.clear_last = (clr_cnt == IDX_W'(STORE_DEPTH - 1));

  // One port serves the sweep, the read and the write-back of an AND update.
  always_comb begin
    if (cmd.clear_en) begin
      ram_addr  = clr_cnt;
      ram_we    = 1'b1;
      ram_wdata = ERASED_BYTE;
    end else begin
      ram_addr  = store_index(address_shift);
      ram_we    = cmd.finish && rmw_q;
      ram_wdata = ram_rdata & data_latch;
    end
  end

  kdep_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign sel     = last_port_b[SEL_W-1:0];
  assign key_sel = (sel >= KEY_SEL_FIRST) && (sel <= KEY_SEL_LAST);
  assign key_idx = 2'(sel - KEY_SEL_FIRST);

  always_comb begin
    read_data   = '0;
    digit_valid = 1'b0;
    digit_index = '0;
    segments    = '0;
    case (cmd_q)
      CMD_WR_A: begin
        if (sel < DIGIT_COUNT) begin
          digit_valid = 1'b1;
          digit_index = sel[2:0];
          segments    = segment_pattern(value_q);
        end
      end
      CMD_RD_A: begin
        if (key_sel) begin
          read_data = {KEY_PAD_BITS, rows_q[key_idx]};
        end else if (!last_port_b[6] && !last_port_b[7]) begin
          read_data = ram_rdata;
        end else begin
          read_data = ERASED_BYTE;
        end
      end
      default: ;
    endcase
  end

  assign speaker_level = ~last_port_b[4];
  assign address_led   = last_port_b[5];
  assign data_led      = ~last_port_b[5];
  assign eprom_address = address_shift;

endmodule

### rtl/kdep_checker.sv
`include "keypad_display_eprom_port_logic_assert.svh"

module kdep_port_props (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic       digit_valid,
  input logic [2:0] digit_index,
  input logic       address_led,
  input logic       data_led
);

  // The store sweep starts right after reset, so the block is busy.
  `KDEP_ASSERT_ALWAYS(a_busy_after_reset, rst |=> busy, "not busy after reset")

  // An accepted word raises done once the controller has passed the read state.
  `KDEP_ASSERT(a_latency, start && !busy |-> ##2 done, "result latency broken")

  // A result strobe lasts exactly one cycle.
  `KDEP_ASSERT(a_done_pulse, done |=> !done, "done held for two cycles")

  // A digit update names one of the six digits.
  `KDEP_ASSERT(a_digit_range, done && digit_valid |-> digit_index < 3'd6,
               "digit index out of range")

  // The two LEDs are driven from the same port bit in opposite sense.
  `KDEP_ASSERT(a_led_pair, address_led != data_led, "LED outputs agree")

endmodule

bind keypad_display_eprom_port_logic kdep_port_props u_kdep_port_props (.*);
